// File: design/ptas_pkg.sv
package ptas_pkg;

  // scaled gas constant over static pressure
  localparam logic [12:0] GAS_NUM   = 13'd5741;
  localparam logic [19:0] SPEED_DEN = 20'd1013250;
  localparam logic [21:0] VAR_DEN   = 22'd4053000;
  localparam logic [31:0] VAR_MAX   = 32'hFFFF_FFFF;

  localparam int ROOT_STAGES = 17;
  localparam int DIV_STAGES  = 32;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRESSURE_VAR = 2'd0,
    CFG_TEMP_VAR     = 2'd1,
    CFG_MIN_PRESSURE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [31:0] pressure_var;
    logic [31:0] temp_var;
    logic [15:0] min_pressure;
  } ptas_cfg_t;

  typedef struct packed {
    logic below;
    logic tzero;
    logic sat;
  } ptas_flags_t;

  typedef struct packed {
    logic [91:0] num;
    logic [61:0] den;
    ptas_flags_t flags;
  } ptas_div_op_t;

  typedef struct packed {
    logic [16:0] speed;
    logic [31:0] variance;
    logic        below;
  } ptas_result_t;

endpackage

// File: design/ptas_in_if.sv
interface ptas_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] press_diff;
  logic [16:0]        temperature;

  modport source(output valid, press_diff, temperature, input ready);
  modport sink(input valid, press_diff, temperature, output ready);
endinterface

// File: design/ptas_out_if.sv
interface ptas_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] air_speed;
  logic [31:0] speed_variance;
  logic        below_minimum;

  modport source(output valid, air_speed, speed_variance, below_minimum, input ready);
  modport sink(input valid, air_speed, speed_variance, below_minimum, output ready);
endinterface

// File: design/ptas_front.sv
module ptas_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ptas_pkg::ptas_cfg_t     cfg,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [23:0]      up_dp,
  input  logic [16:0]             up_tq,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [52:0]             dn_rad,
  output ptas_pkg::ptas_div_op_t  dn_op
);
  import ptas_pkg::*;

  localparam int NST = 6;

  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  logic [22:0] d0_r;
  logic [16:0] tq0_r;
  ptas_flags_t f0_r, f1_r, f2_r, f3_r, f4_r, f5_r;
  logic [39:0] dt1_r;
  logic [33:0] tq2_1_r;
  logic [45:0] d2_1_r;
  logic [48:0] alo2_r, ahi2_r;
  logic [54:0] blo2_r, bhi2_r;
  logic [52:0] rad2_r, rad3_r, rad4_r, rad5_r;
  logic [61:0] den2_r, den3_r, den4_r, den5_r;
  logic [78:0] sum3_r;
  logic [91:0] num4_r, num5_r;
  logic        below_in;

  // stall chain: a stage takes data when empty or draining
  always_comb begin
    rdy[NST] = dn_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // negative or small pressure
  assign below_in = up_dp[23] || ({1'b0, up_dp[22:0]} <= {8'b0, cfg.min_pressure});

  always_ff @(posedge clk) begin
    // capture sample
    if (rdy[0]) begin
      d0_r        <= up_dp[22:0];
      tq0_r       <= up_tq;
      f0_r.below  <= below_in;
      f0_r.tzero  <= (up_tq == 17'd0);
      f0_r.sat    <= 1'b0;
    end
    // products of the sample
    if (rdy[1]) begin
      dt1_r   <= 40'(d0_r) * 40'(tq0_r);
      tq2_1_r <= 34'(tq0_r) * 34'(tq0_r);
      d2_1_r  <= 46'(d0_r) * 46'(d0_r);
      f1_r    <= f0_r;
    end
    // variance partial products and constant scaling
    if (rdy[2]) begin
      alo2_r <= 49'(tq2_1_r[16:0]) * 49'(cfg.pressure_var);
      ahi2_r <= 49'(tq2_1_r[33:17]) * 49'(cfg.pressure_var);
      blo2_r <= 55'(d2_1_r[22:0]) * 55'(cfg.temp_var);
      bhi2_r <= 55'(d2_1_r[45:23]) * 55'(cfg.temp_var);
      rad2_r <= 53'(dt1_r) * 53'(GAS_NUM);
      den2_r <= 62'(dt1_r) * 62'(VAR_DEN);
      f2_r   <= f1_r;
    end
    // combine partial products
    if (rdy[3]) begin
      sum3_r <= 79'(alo2_r) + (79'(ahi2_r) << 17) + 79'(blo2_r) + (79'(bhi2_r) << 23);
      rad3_r <= rad2_r;
      den3_r <= den2_r;
      f3_r   <= f2_r;
    end
    // scale numerator
    if (rdy[4]) begin
      num4_r <= 92'(sum3_r) * 92'(GAS_NUM);
      rad4_r <= rad3_r;
      den4_r <= den3_r;
      f4_r   <= f3_r;
    end
    // quotient overflow check
    if (rdy[5]) begin
      num5_r      <= num4_r;
      den5_r      <= den4_r;
      rad5_r      <= rad4_r;
      f5_r.below  <= f4_r.below;
      f5_r.tzero  <= f4_r.tzero;
      f5_r.sat    <= ({2'b0, num4_r} >= {den4_r, 32'b0});
    end
  end

  assign dn_valid     = v_r[NST-1];
  assign dn_rad       = rad5_r;
  assign dn_op.num    = num5_r;
  assign dn_op.den    = den5_r;
  assign dn_op.flags  = f5_r;

endmodule

// File: design/ptas_root.sv
module ptas_root (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [52:0]             up_rad,
  input  ptas_pkg::ptas_div_op_t  up_op,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [16:0]             dn_speed,
  output ptas_pkg::ptas_div_op_t  dn_op
);
  import ptas_pkg::*;

  logic [ROOT_STAGES-1:0] v_r;
  logic [ROOT_STAGES:0]   rdy;
  logic [52:0]  rem_r  [ROOT_STAGES];
  logic [16:0]  root_r [ROOT_STAGES];
  logic [36:0]  c_r    [ROOT_STAGES];
  ptas_div_op_t op_r   [ROOT_STAGES];

  always_comb begin
    rdy[ROOT_STAGES] = dn_ready;
    for (int i = ROOT_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int i = 1; i < ROOT_STAGES; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // one root bit per stage, msb first; c tracks SPEED_DEN * root
  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_st
    localparam int B = ROOT_STAGES - 1 - k;
    logic [52:0]  rem_in;
    logic [16:0]  root_in;
    logic [36:0]  c_in;
    ptas_div_op_t op_in;
    logic [55:0]  term;
    logic         take;

    if (k == 0) begin : g_first
      assign rem_in  = up_rad;
      assign root_in = '0;
      assign c_in    = '0;
      assign op_in   = up_op;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign c_in    = c_r[k-1];
      assign op_in   = op_r[k-1];
    end

    assign term = (56'(c_in) << (B + 1)) + (56'(SPEED_DEN) << (2 * B));
    assign take = ({3'b0, rem_in} >= term);

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[k]  <= take ? (rem_in - term[52:0]) : rem_in;
        root_r[k] <= root_in | (17'(take) << B);
        c_r[k]    <= take ? (c_in + (37'(SPEED_DEN) << B)) : c_in;
        op_r[k]   <= op_in;
      end
    end
  end

  assign dn_valid = v_r[ROOT_STAGES-1];
  assign dn_speed = root_r[ROOT_STAGES-1];
  assign dn_op    = op_r[ROOT_STAGES-1];

endmodule

// File: design/ptas_div.sv
module ptas_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [16:0]             up_speed,
  input  ptas_pkg::ptas_div_op_t  up_op,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output ptas_pkg::ptas_result_t  dn_res
);
  import ptas_pkg::*;

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES:0]   rdy;
  logic [91:0]  rem_r   [DIV_STAGES];
  logic [31:0]  q_r     [DIV_STAGES];
  logic [61:0]  den_r   [DIV_STAGES];
  logic [16:0]  speed_r [DIV_STAGES];
  ptas_flags_t  f_r     [DIV_STAGES];

  always_comb begin
    rdy[DIV_STAGES] = dn_ready;
    for (int i = DIV_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int i = 1; i < DIV_STAGES; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    localparam int B = DIV_STAGES - 1 - k;
    logic [91:0] rem_in;
    logic [31:0] q_in;
    logic [61:0] den_in;
    logic [16:0] speed_in;
    ptas_flags_t f_in;
    logic [93:0] sub;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_in   = up_op.num;
      assign q_in     = '0;
      assign den_in   = up_op.den;
      assign speed_in = up_speed;
      assign f_in     = up_op.flags;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign q_in     = q_r[k-1];
      assign den_in   = den_r[k-1];
      assign speed_in = speed_r[k-1];
      assign f_in     = f_r[k-1];
    end

    assign sub  = 94'(den_in) << B;
    assign take = ({2'b0, rem_in} >= sub);

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[k]   <= take ? (rem_in - sub[91:0]) : rem_in;
        q_r[k]     <= q_in | (32'(take) << B);
        den_r[k]   <= den_in;
        speed_r[k] <= speed_in;
        f_r[k]     <= f_in;
      end
    end
  end

  // special cases override the computed values
  always_comb begin
    dn_res.below = 1'b0;
    if (f_r[DIV_STAGES-1].below) begin
      dn_res.speed    = '0;
      dn_res.variance = '0;
      dn_res.below    = 1'b1;
    end else if (f_r[DIV_STAGES-1].tzero) begin
      dn_res.speed    = '0;
      dn_res.variance = VAR_MAX;
    end else if (f_r[DIV_STAGES-1].sat) begin
      dn_res.speed    = speed_r[DIV_STAGES-1];
      dn_res.variance = VAR_MAX;
    end else begin
      dn_res.speed    = speed_r[DIV_STAGES-1];
      dn_res.variance = q_r[DIV_STAGES-1];
    end
  end

  assign dn_valid = v_r[DIV_STAGES-1];

endmodule

// File: design/pitot_true_airspeed_with_variance_top.sv
// pipeline: 6 front stages for products and scaling, 17 square-root stages
// and 32 divider stages, one result bit per root or divider stage
// throughput: one request per cycle; each stage holds under backpressure
// and a bubble anywhere lets new requests in
// reset: synchronous active-low rst_n clears all stage valid bits and
// loads the variance registers with 65536 and the minimum pressure with 26
module pitot_true_airspeed_with_variance_top (
  input  logic        clk,
  input  logic        rst_n,
  ptas_in_if.sink     in_ch,
  ptas_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import ptas_pkg::*;

  ptas_cfg_t    cfg_r;
  logic         f_valid, f_ready, r_valid, r_ready;
  logic [52:0]  f_rad;
  ptas_div_op_t f_op, r_op;
  logic [16:0]  r_speed;
  ptas_result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressure_var <= 32'd65536;
      cfg_r.temp_var     <= 32'd65536;
      cfg_r.min_pressure <= 16'd26;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESSURE_VAR: cfg_r.pressure_var <= cfg_wdata;
        CFG_TEMP_VAR:     cfg_r.temp_var     <= cfg_wdata;
        CFG_MIN_PRESSURE: cfg_r.min_pressure <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  ptas_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_dp    (in_ch.press_diff),
    .up_tq    (in_ch.temperature),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_rad   (f_rad),
    .dn_op    (f_op)
  );

  ptas_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_rad   (f_rad),
    .up_op    (f_op),
    .dn_valid (r_valid),
    .dn_ready (r_ready),
    .dn_speed (r_speed),
    .dn_op    (r_op)
  );

  ptas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (r_valid),
    .up_ready (r_ready),
    .up_speed (r_speed),
    .up_op    (r_op),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_res   (res)
  );

  assign out_ch.air_speed      = res.speed;
  assign out_ch.speed_variance = res.variance;
  assign out_ch.below_minimum  = res.below;

endmodule
